### sv/div64_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// div64_pkg
// Shared constants, controller states and the command and status bundles
// between the divider controller and datapath.
// ----------------------------------------------------------------------------
package div64_pkg;

  localparam int FIELD_W    = 64;
  localparam int DATA_WIDTH = 64;
  localparam int CNT_W      = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIX  = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic step;
    logic fix;
  } cmd_t;

  typedef struct packed {
    logic div_zero;
    logic last_step;
    logic out_full;
  } sts_t;

endpackage

`default_nettype wire

### sv/div64_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// div64_ctrl
// Sequencer for the divider: capture, sign prep, one step per quotient bit,
// then sign fix-up into the output register.
// ----------------------------------------------------------------------------
module div64_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  div64_pkg::sts_t   sts,
  output div64_pkg::cmd_t   cmd
);

  div64_pkg::state_t state;
  div64_pkg::state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      div64_pkg::ST_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_next = div64_pkg::ST_PREP;
      end
      div64_pkg::ST_PREP: begin
        cmd.prep = 1'b1;
        state_next = sts.div_zero ? div64_pkg::ST_FIX : div64_pkg::ST_DIV;
      end
      div64_pkg::ST_DIV: begin
        cmd.step = 1'b1;
        if (sts.last_step) state_next = div64_pkg::ST_FIX;
      end
      div64_pkg::ST_FIX: begin
        cmd.fix = !sts.out_full;
        if (!sts.out_full) state_next = div64_pkg::ST_IDLE;
      end
      default: begin
        state_next = div64_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= div64_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == div64_pkg::ST_IDLE);

endmodule

`default_nettype wire

### sv/div64_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// div64_dpath
// Operand registers, magnitude prep, restoring shift-subtract step,
// sign fix-up and the output register.
// ----------------------------------------------------------------------------
module div64_dpath (
  input  logic                           clk,
  input  logic                           rst,
  input  div64_pkg::cmd_t                cmd,
  output div64_pkg::sts_t                sts,
  input  logic                           in_kind,
  input  logic [div64_pkg::FIELD_W-1:0]  in_dividend,
  input  logic [div64_pkg::FIELD_W-1:0]  in_divisor,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [div64_pkg::FIELD_W-1:0]  out_quotient,
  output logic [div64_pkg::FIELD_W-1:0]  out_remainder,
  output logic                           out_div_zero
);

  localparam int W = div64_pkg::DATA_WIDTH;

  logic                           sgn;
  logic [W-1:0]                   n_raw;
  logic [W-1:0]                   d_raw;
  logic                           n_neg;
  logic                           d_neg;
  logic [W-1:0]                   nsh;
  logic [W-1:0]                   dv;
  logic [W-1:0]                   rem;
  logic [W-1:0]                   quo;
  logic [div64_pkg::CNT_W-1:0]    cnt;

  logic                           carry;
  logic [W-1:0]                   shifted;
  logic [W:0]                     diff;
  logic                           fits;
  logic [W-1:0]                   q_fix;
  logic [W-1:0]                   r_fix;

  assign carry   = rem[W-1];
  assign shifted = {rem[W-2:0], nsh[W-1]};
  assign diff    = {carry, shifted} - {1'b0, dv};
  assign fits    = carry || !diff[W];

  assign q_fix = sts.div_zero ? '0 : ((n_neg ^ d_neg) ? (W'(0) - quo) : quo);
  assign r_fix = sts.div_zero ? n_raw : (n_neg ? (W'(0) - rem) : rem);

  assign sts.div_zero  = (d_raw == '0);
  assign sts.last_step = (cnt == '0);
  assign sts.out_full  = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sgn   <= in_kind;
      n_raw <= in_dividend[W-1:0];
      d_raw <= in_divisor[W-1:0];
    end
    if (cmd.prep) begin
      n_neg <= sgn && n_raw[W-1];
      d_neg <= sgn && d_raw[W-1];
      nsh   <= (sgn && n_raw[W-1]) ? (W'(0) - n_raw) : n_raw;
      dv    <= (sgn && d_raw[W-1]) ? (W'(0) - d_raw) : d_raw;
      rem   <= '0;
      quo   <= '0;
      cnt   <= div64_pkg::CNT_W'(W - 1);
    end
    if (cmd.step) begin
      rem <= fits ? diff[W-1:0] : shifted;
      quo <= {quo[W-2:0], fits};
      nsh <= {nsh[W-2:0], 1'b0};
      cnt <= cnt - 1'b1;
    end
    if (cmd.fix) begin
      out_quotient  <= div64_pkg::FIELD_W'(q_fix);
      out_remainder <= div64_pkg::FIELD_W'(r_fix);
      out_div_zero  <= sts.div_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fix) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### sv/divider_64bit_signed_unsigned_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// divider_64bit_signed_unsigned_unit
// Radix-2 restoring divider, signed or unsigned, with zero-divisor flag.
// ----------------------------------------------------------------------------
// One word in, one word out. A word is taken when the unit is free, then the
// operands are turned into magnitudes, the shift-subtract loop produces one
// quotient bit per cycle, and the sign fix-up writes the output register. A
// new word is taken only once the previous result has been written there,
// and that write waits while an earlier result is still held; a zero
// divisor skips the loop. The result waits in the output register, so the
// next word is already being divided while it is held. Signed quotients
// truncate toward zero, the remainder carries the dividend's sign, and the
// most negative value over -1 wraps. A zero divisor raises tuser with
// quotient 0 and remainder equal to the dividend.
// ----------------------------------------------------------------------------
module divider_64bit_signed_unsigned_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [63:0] dividend, [127:64] divisor
  input  logic [2*div64_pkg::FIELD_W-1:0]   s_axis_tdata,
  // [0] kind (0 unsigned, 1 signed)
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [63:0] quotient, [127:64] remainder
  output logic [2*div64_pkg::FIELD_W-1:0]   m_axis_tdata,
  // [0] divide_by_zero
  output logic                              m_axis_tuser
);

  div64_pkg::cmd_t cmd;
  div64_pkg::sts_t sts;

  logic [div64_pkg::FIELD_W-1:0] quotient;
  logic [div64_pkg::FIELD_W-1:0] remainder;

  div64_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  div64_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_kind       (s_axis_tuser),
    .in_dividend   (s_axis_tdata[div64_pkg::FIELD_W-1:0]),
    .in_divisor    (s_axis_tdata[2*div64_pkg::FIELD_W-1:div64_pkg::FIELD_W]),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_quotient  (quotient),
    .out_remainder (remainder),
    .out_div_zero  (m_axis_tuser)
  );

  assign m_axis_tdata = {remainder, quotient};

endmodule

`default_nettype wire

### sv/div64_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// div64_chk
// Port-level checks for the divider, bound to the top level.
// ----------------------------------------------------------------------------
module div64_chk (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [2*div64_pkg::FIELD_W-1:0]   m_axis_tdata,
  input  logic                              m_axis_tuser
);

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> !s_axis_tready)
    else $error("second word taken while dividing");

  a_lat: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> ##1 !$rose(m_axis_tvalid))
    else $error("result appeared too early");

  a_dz: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[div64_pkg::FIELD_W-1:0] == '0)
    else $error("zero-divisor result has nonzero quotient");

endmodule

bind divider_64bit_signed_unsigned_unit div64_chk u_div64_chk (.*);

`default_nettype wire
